FILE: hw/rtl/srs_pkg.sv
// shared types and constants of the stereo linear resampler
package srs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SMP_W     = 16;
  localparam int STEP_W    = 20;
  localparam int PHASE_W   = 21;
  localparam int WGT_W     = FRAC_BITS + 2;
  localparam int PROD_W    = SMP_W + WGT_W;
  localparam int SUM_W     = SMP_W + 2;
  localparam int MAX_OUT   = 16;
  localparam int CNT_W     = $clog2(MAX_OUT);
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [PHASE_W-1:0] ONE_UNIT  = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAX_OUT - 1);

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } pair_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic                    last;
  } res_t;

endpackage

FILE: hw/rtl/stereo_linear_resampler.sv
// top level of the stereo linear resampler
//
// each pushed word is one stereo pair of 16-bit source samples; the block keeps
// a 21-bit phase (16 fraction bits) and the previous pair, and while the phase
// is below one unit it pops out an interpolated pair,
// floor(prev*(1-f)) + floor(cur*f) per channel, saturated to 16 bits, then adds
// the configured step; once the phase reaches one unit it drops one unit and the
// current pair becomes the previous one. a word may give no output or up to 16,
// and the final one of a run (phase wrap or 16th output) has last_of_run set.
// every output goes through a multiply step and an add/saturate step of the
// single interpolation datapath and waits while the result queue is full; a new
// word is taken only after the last output of the current one. two-deep queues
// sit on both sides, so pushes keep going while results wait to be popped.
// phase_step is written over the cfg port (always ready) and must only change
// while the block is idle; reset sets it to one unit (pass-through rate).
module stereo_linear_resampler (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [srs_pkg::SMP_W-1:0]    in_left_sample,
  input  logic signed [srs_pkg::SMP_W-1:0]    in_right_sample,
  // result words
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [srs_pkg::SMP_W-1:0]    out_left_out,
  output logic signed [srs_pkg::SMP_W-1:0]    out_right_out,
  output logic                                out_last_of_run,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srs_pkg::STEP_W-1:0]          cfg_phase_step
);
  import srs_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  pair_t             in_word;
  pair_t             item;
  logic              item_empty, item_pop;
  res_t              res, out_word;
  logic              res_push, res_full;

  // config register; cfg_ready is tied high, so every cfg_valid writes it
  assign cfg_ready = 1'b1;

  always_comb begin
    step_nxt = step_r;
    if (cfg_valid && cfg_ready) begin
      step_nxt = cfg_phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RST;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_word.left  = in_left_sample;
  assign in_word.right = in_right_sample;

  // front: buffer incoming pairs
  srs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .wr_word (in_word),
    .pop     (item_pop),
    .empty   (item_empty),
    .rd_word (item)
  );

  // back: phase walk and interpolation
  srs_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step_r),
    .item_avail (!item_empty),
    .item       (item),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  // results wait here until popped
  srs_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (res_full),
    .wr_word (res),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_word (out_word)
  );

  assign out_left_out    = out_word.left;
  assign out_right_out   = out_word.right;
  assign out_last_of_run = out_word.last;

`ifndef SYNTHESIS
  // the sequencer never pushes into a full result queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed while queue full");

  // the sequencer never takes a word from an empty input queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> !item_empty)
    else $error("input popped while queue empty");

  // nothing is offered right after reset
  a_empty_after_rst: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result offered after reset");
`endif

endmodule

FILE: hw/rtl/srs_front.sv
// input side: short queue of stereo source words
module srs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  srs_pkg::pair_t wr_word,
  input  logic          pop,
  output logic          empty,
  output srs_pkg::pair_t rd_word
);
  import srs_pkg::*;

  pair_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, wp_nxt;
  logic [Q_AW-1:0]  rp_r, rp_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_word = mem_r[rp_r];
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;

  always_comb begin
    wp_nxt  = do_wr ? Q_AW'((32'(wp_r) + 1) % Q_DEPTH) : wp_r;
    rp_nxt  = do_rd ? Q_AW'((32'(rp_r) + 1) % Q_DEPTH) : rp_r;
    cnt_nxt = cnt_r + Q_CW'(do_wr) - Q_CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_word;
    end
  end

endmodule

FILE: hw/rtl/srs_interp.sv
// back end: phase sequencer and interpolation datapath
module srs_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [srs_pkg::STEP_W-1:0]  step,
  input  logic                        item_avail,
  input  srs_pkg::pair_t              item,
  output logic                        item_pop,
  output logic                        res_push,
  output srs_pkg::res_t               res,
  input  logic                        res_full
);
  import srs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  pair_t                    prev_r, prev_nxt;
  pair_t                    cur_r, cur_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] pl_r, cl_r, pr_r, cr_r;
  logic signed [WGT_W-1:0]  w_cur, w_prev;
  logic signed [SUM_W-1:0]  sum_l, sum_r;
  logic [PHASE_W-1:0]       phase_add;
  logic                     wrap, last;

  function automatic logic signed [SUM_W-1:0] floor_w(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'((1 << (SMP_W - 1)) - 1);
    lo = -SUM_W'(1 << (SMP_W - 1));
    if (v > hi) return hi[SMP_W-1:0];
    else if (v < lo) return lo[SMP_W-1:0];
    else return v[SMP_W-1:0];
  endfunction

  // phase is below one unit in the multiply state, so the weights fit
  assign w_cur  = WGT_W'(phase_r[FRAC_BITS:0]);
  assign w_prev = WGT_W'(ONE_UNIT[FRAC_BITS:0] - phase_r[FRAC_BITS:0]);

  assign sum_l = floor_w(pl_r) + floor_w(cl_r);
  assign sum_r = floor_w(pr_r) + floor_w(cr_r);

  assign phase_add = phase_r + PHASE_W'(step);
  assign wrap      = (phase_add >= ONE_UNIT);
  assign last      = wrap || (cnt_r == CNT_LAST);

  assign res.left  = sat(sum_l);
  assign res.right = sat(sum_r);
  assign res.last  = last;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_avail) begin
          item_pop = 1'b1;
          cur_nxt  = item;
          cnt_nxt  = '0;
          if (phase_r >= ONE_UNIT) begin
            // no output for this word
            phase_nxt = phase_r - ONE_UNIT;
            prev_nxt  = item;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          phase_nxt = wrap ? (phase_add - ONE_UNIT) : phase_add;
          if (last) begin
            prev_nxt  = cur_r;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (state_r == S_MUL) begin
      pl_r <= PROD_W'(prev_r.left)  * PROD_W'(w_prev);
      cl_r <= PROD_W'(cur_r.left)   * PROD_W'(w_cur);
      pr_r <= PROD_W'(prev_r.right) * PROD_W'(w_prev);
      cr_r <= PROD_W'(cur_r.right)  * PROD_W'(w_cur);
    end
  end

endmodule

FILE: hw/rtl/srs_outq.sv
// result side: short queue of interpolated words
module srs_outq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  srs_pkg::res_t wr_word,
  input  logic         pop,
  output logic         empty,
  output srs_pkg::res_t rd_word
);
  import srs_pkg::*;

  res_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, wp_nxt;
  logic [Q_AW-1:0]  rp_r, rp_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_word = mem_r[rp_r];
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;

  always_comb begin
    wp_nxt  = do_wr ? Q_AW'((32'(wp_r) + 1) % Q_DEPTH) : wp_r;
    rp_nxt  = do_rd ? Q_AW'((32'(rp_r) + 1) % Q_DEPTH) : rp_r;
    cnt_nxt = cnt_r + Q_CW'(do_wr) - Q_CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_word;
    end
  end

endmodule
